>>> hdl/grid_great_circle_distance_core_assert.svh
// Assertion macros shared by the distance core
`ifndef GRID_GREAT_CIRCLE_DISTANCE_CORE_ASSERT_SVH
`define GRID_GREAT_CIRCLE_DISTANCE_CORE_ASSERT_SVH

// check a property on every clock edge out of reset
`define GGCD_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check that a condition is followed by a consequence in the next cycle
`define GGCD_ASSERT_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/ggcd_pkg.sv
package ggcd_pkg;

  localparam int GRID_COLUMNS = 744;
  localparam int GRID_ROWS    = 500;

  localparam int COL_W    = 10;
  localparam int ROW_W    = 9;
  localparam int IN_W     = 40;
  localparam int OUT_W    = 24;
  localparam int DIST_W   = 22;
  localparam int RADIUS_W = 16;
  localparam int NUM_W    = 13;
  localparam int FRAC_W   = 28;
  localparam int STEPS    = 30;
  localparam int SQ_STEPS = 31;
  localparam int DEPTH    = 100;
  localparam int H_STAGE  = 35;
  localparam int SQ_END   = 66;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd6371;
  localparam logic [DIST_W-1:0]   DIST_SAT     = {DIST_W{1'b1}};

  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [30:0] ONE_Q30 = 31'd1073741824;

  typedef logic signed [33:0] cw_t;

  localparam cw_t GAIN_Q30 = 34'sd652032874;

  localparam logic [63:0] ROW_DEN = 64'(2 * GRID_ROWS);
  localparam logic [63:0] COL_DEN = 64'(GRID_COLUMNS);
  localparam logic [63:0] ROW_QUO = PI_Q30 / ROW_DEN;
  localparam logic [63:0] ROW_REM = PI_Q30 % ROW_DEN;
  localparam logic [63:0] COL_QUO = PI_Q30 / COL_DEN;
  localparam logic [63:0] COL_REM = PI_Q30 % COL_DEN;
  localparam int          ROW_SH  = FRAC_W + $clog2(2 * GRID_ROWS) + 1;
  localparam int          COL_SH  = FRAC_W + $clog2(GRID_COLUMNS) + 1;
  localparam logic [63:0] ROW_MUL = ((64'd1 << ROW_SH) + ROW_DEN - 64'd1) / ROW_DEN;
  localparam logic [63:0] COL_MUL = ((64'd1 << COL_SH) + COL_DEN - 64'd1) / COL_DEN;

  function automatic logic [31:0] atan_q30(input int i);
    logic [31:0] r;
    case (i)
      0:  r = 32'h3243F6A8;
      1:  r = 32'h1DAC6705;
      2:  r = 32'h0FADBAFC;
      3:  r = 32'h07F56EA6;
      4:  r = 32'h03FEAB76;
      5:  r = 32'h01FFD55B;
      6:  r = 32'h00FFFAAA;
      7:  r = 32'h007FFF55;
      8:  r = 32'h003FFFEA;
      9:  r = 32'h001FFFFD;
      10: r = 32'h000FFFFF;
      11: r = 32'h0007FFFF;
      12: r = 32'h0003FFFF;
      13: r = 32'h0001FFFF;
      14: r = 32'h0000FFFF;
      15: r = 32'h00007FFF;
      16: r = 32'h00003FFF;
      17: r = 32'h00001FFF;
      18: r = 32'h00000FFF;
      19: r = 32'h000007FF;
      20: r = 32'h000003FF;
      21: r = 32'h000001FF;
      22: r = 32'h000000FF;
      23: r = 32'h0000007F;
      24: r = 32'h0000003F;
      25: r = 32'h0000001F;
      26: r = 32'h0000000F;
      27: r = 32'h00000007;
      28: r = 32'h00000003;
      29: r = 32'h00000001;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  function automatic logic [30:0] mul_q30(input logic [30:0] a, input logic [30:0] b);
    logic [61:0] p;
    p = 62'(a) * 62'(b) + 62'(64'd1 << 29);
    return p[60:30];
  endfunction

  function automatic logic [30:0] sin_mag(input cw_t v);
    logic [30:0] r;
    if (v > cw_t'({3'b000, ONE_Q30}) || v < -cw_t'({3'b000, ONE_Q30})) begin
      r = ONE_Q30;
    end else if (v < 0) begin
      r = 31'(-v);
    end else begin
      r = v[30:0];
    end
    return r;
  endfunction

  function automatic logic [30:0] cos_clamp(input cw_t v);
    logic [30:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > cw_t'({3'b000, ONE_Q30})) begin
      r = ONE_Q30;
    end else begin
      r = v[30:0];
    end
    return r;
  endfunction

endpackage

>>> hdl/grid_great_circle_distance_core.sv
// Great-circle distance between two map grid cells.
// Input words arrive on s_axis (col_a, row_a, col_b, row_b); each gives one
// output word on m_axis: the haversine distance in km with 4 fraction bits.
// cfg_we_i writes the sphere radius (km); write it only while idle.
// One word is taken every cycle unless the output stalls. The pipeline
// is the chain of CORDIC rotation stages (30), digit-per-stage square
// roots (31) and CORDIC vectoring stages (30), plus angle scaling,
// products and the radius multiply.
// Columns at or past the grid width wrap once; rows past GRID_ROWS
// (500) saturate to 500.
// Reset clears all valid bits and restores the radius to 6371 km.
// When the receiver holds m_axis_tready low with a word waiting, the
// whole pipeline holds and s_axis_tready falls; nothing is lost or
// repeated, and flow resumes in the cycle the word is taken.
`include "grid_great_circle_distance_core_assert.svh"

module grid_great_circle_distance_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // col_a[9:0], row_a[18:10], col_b[28:19], row_b[37:29], zero fill
  input  logic [ggcd_pkg::IN_W-1:0]      s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // distance_km_q4[21:0], zero fill
  output logic [ggcd_pkg::OUT_W-1:0]     m_axis_tdata,
  input  logic                           cfg_we_i,
  input  logic [ggcd_pkg::RADIUS_W-1:0]  cfg_wdata_i
);

  localparam int NW = ggcd_pkg::NUM_W;
  localparam int SS = ggcd_pkg::STEPS;
  localparam int QS = ggcd_pkg::SQ_STEPS;
  localparam int DP = ggcd_pkg::DEPTH;

  logic                          en;
  logic [DP-1:0]                 vld_q;
  logic [ggcd_pkg::RADIUS_W-1:0] radius_q;

  logic [ggcd_pkg::COL_W-1:0] ca, cb, ca_raw, cb_raw;
  logic [NW-1:0]              ra, rb, dr, dc_abs, dc, na, nb;
  logic [NW-1:0]              num_d [4];
  logic [NW-1:0]              num_q [4];
  logic [31:0]                qn_q  [4];
  logic [ggcd_pkg::FRAC_W-1:0] fr_q [4];

  ggcd_pkg::cw_t cx_q [4][SS+1];
  ggcd_pkg::cw_t cy_q [4][SS+1];
  ggcd_pkg::cw_t cz_q [4][SS+1];

  logic [30:0] hvlat_q, hvlon_q, cc_q, hvlat2_q, t_q;
  logic [31:0] hsum;
  logic [30:0] h_d;

  logic [33:0] srem_q  [2][QS+1];
  logic [30:0] sroot_q [2][QS+1];
  logic [30:0] sarg_q  [2][QS+1];

  ggcd_pkg::cw_t ax_q [SS+1];
  ggcd_pkg::cw_t ay_q [SS+1];
  ggcd_pkg::cw_t az_q [SS+1];

  logic [32:0] zc;
  logic [49:0] prod_q;
  logic [49:0] prod_r;
  logic [23:0] dist_raw;
  logic [ggcd_pkg::DIST_W-1:0] dist_q;

  assign en            = !vld_q[DP-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[DP-1];
  assign m_axis_tdata  = {{(ggcd_pkg::OUT_W - ggcd_pkg::DIST_W){1'b0}}, dist_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      radius_q <= ggcd_pkg::RADIUS_RESET;
    end else begin
      if (en) begin
        vld_q <= {vld_q[DP-2:0], s_axis_tvalid};
      end
      if (cfg_we_i) begin
        radius_q <= cfg_wdata_i;
      end
    end
  end

  // wrap columns, saturate rows, form the angle numerators
  always_comb begin
    ca_raw = s_axis_tdata[9:0];
    cb_raw = s_axis_tdata[28:19];
    ca = (ca_raw >= ggcd_pkg::COL_W'(ggcd_pkg::GRID_COLUMNS)) ?
         ca_raw - ggcd_pkg::COL_W'(ggcd_pkg::GRID_COLUMNS) : ca_raw;
    cb = (cb_raw >= ggcd_pkg::COL_W'(ggcd_pkg::GRID_COLUMNS)) ?
         cb_raw - ggcd_pkg::COL_W'(ggcd_pkg::GRID_COLUMNS) : cb_raw;
    ra = NW'(s_axis_tdata[18:10]);
    rb = NW'(s_axis_tdata[37:29]);
    if (ra > NW'(ggcd_pkg::GRID_ROWS)) ra = NW'(ggcd_pkg::GRID_ROWS);
    if (rb > NW'(ggcd_pkg::GRID_ROWS)) rb = NW'(ggcd_pkg::GRID_ROWS);
    dr = (ra > rb) ? ra - rb : rb - ra;
    na = ({ra[NW-2:0], 1'b0} > NW'(ggcd_pkg::GRID_ROWS)) ?
         {ra[NW-2:0], 1'b0} - NW'(ggcd_pkg::GRID_ROWS) :
         NW'(ggcd_pkg::GRID_ROWS) - {ra[NW-2:0], 1'b0};
    nb = ({rb[NW-2:0], 1'b0} > NW'(ggcd_pkg::GRID_ROWS)) ?
         {rb[NW-2:0], 1'b0} - NW'(ggcd_pkg::GRID_ROWS) :
         NW'(ggcd_pkg::GRID_ROWS) - {rb[NW-2:0], 1'b0};
    dc_abs = (ca > cb) ? NW'(ca - cb) : NW'(cb - ca);
    dc = ({dc_abs[NW-2:0], 1'b0} > NW'(ggcd_pkg::GRID_COLUMNS)) ?
         NW'(ggcd_pkg::GRID_COLUMNS) - dc_abs : dc_abs;
    num_d[0] = dr;
    num_d[1] = na;
    num_d[2] = nb;
    num_d[3] = dc;
  end

  for (genvar j = 0; j < 4; j++) begin : g_lane
    localparam logic [63:0] LQ = (j == 3) ? ggcd_pkg::COL_QUO : ggcd_pkg::ROW_QUO;
    localparam logic [63:0] LR = (j == 3) ? ggcd_pkg::COL_REM : ggcd_pkg::ROW_REM;
    localparam logic [63:0] LD = (j == 3) ? ggcd_pkg::COL_DEN : ggcd_pkg::ROW_DEN;
    localparam logic [63:0] LM = (j == 3) ? ggcd_pkg::COL_MUL : ggcd_pkg::ROW_MUL;
    localparam int          LS = (j == 3) ? ggcd_pkg::COL_SH  : ggcd_pkg::ROW_SH;

    logic [63:0] qn_full, fr_full, rc_full;
    logic [31:0] ang;

    assign qn_full = LQ * 64'(num_q[j]);
    assign fr_full = LR * 64'(num_q[j]) + (LD >> 1);
    assign rc_full = (64'(fr_q[j]) * LM) >> LS;
    assign ang     = qn_q[j] + rc_full[31:0];

    always_ff @(posedge clk_i) begin
      if (en) begin
        num_q[j]    <= num_d[j];
        qn_q[j]     <= qn_full[31:0];
        fr_q[j]     <= fr_full[ggcd_pkg::FRAC_W-1:0];
        cx_q[j][0]  <= ggcd_pkg::GAIN_Q30;
        cy_q[j][0]  <= '0;
        cz_q[j][0]  <= ggcd_pkg::cw_t'({2'b00, ang});
      end
    end

    for (genvar i = 0; i < SS; i++) begin : g_rot
      localparam ggcd_pkg::cw_t AT = ggcd_pkg::cw_t'({2'b00, ggcd_pkg::atan_q30(i)});
      always_ff @(posedge clk_i) begin
        if (en) begin
          if (!cz_q[j][i][33]) begin
            cx_q[j][i+1] <= cx_q[j][i] - (cy_q[j][i] >>> i);
            cy_q[j][i+1] <= cy_q[j][i] + (cx_q[j][i] >>> i);
            cz_q[j][i+1] <= cz_q[j][i] - AT;
          end else begin
            cx_q[j][i+1] <= cx_q[j][i] + (cy_q[j][i] >>> i);
            cy_q[j][i+1] <= cy_q[j][i] - (cx_q[j][i] >>> i);
            cz_q[j][i+1] <= cz_q[j][i] + AT;
          end
        end
      end
    end
  end

  assign hsum = {1'b0, hvlat2_q} + {1'b0, t_q};
  assign h_d  = (hsum > {1'b0, ggcd_pkg::ONE_Q30}) ? ggcd_pkg::ONE_Q30 : hsum[30:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      hvlat_q <= ggcd_pkg::mul_q30(ggcd_pkg::sin_mag(cy_q[0][SS]),
                                   ggcd_pkg::sin_mag(cy_q[0][SS]));
      hvlon_q <= ggcd_pkg::mul_q30(ggcd_pkg::sin_mag(cy_q[3][SS]),
                                   ggcd_pkg::sin_mag(cy_q[3][SS]));
      cc_q    <= ggcd_pkg::mul_q30(ggcd_pkg::cos_clamp(cx_q[1][SS]),
                                   ggcd_pkg::cos_clamp(cx_q[2][SS]));
      hvlat2_q <= hvlat_q;
      t_q      <= ggcd_pkg::mul_q30(cc_q, hvlon_q);
      srem_q[0][0]  <= '0;
      sroot_q[0][0] <= '0;
      sarg_q[0][0]  <= h_d;
      srem_q[1][0]  <= '0;
      sroot_q[1][0] <= '0;
      sarg_q[1][0]  <= ggcd_pkg::ONE_Q30 - h_d;
    end
  end

  // one root bit per stage
  for (genvar k = 0; k < 2; k++) begin : g_sqrt
    for (genvar i = 0; i < QS; i++) begin : g_bit
      logic [61:0] vfull;
      logic [33:0] remsh, trial;
      assign vfull = {1'b0, sarg_q[k][i], 30'b0};
      assign remsh = {srem_q[k][i][31:0], vfull[61-2*i -: 2]};
      assign trial = {1'b0, sroot_q[k][i], 2'b01};
      always_ff @(posedge clk_i) begin
        if (en) begin
          sarg_q[k][i+1] <= sarg_q[k][i];
          if (remsh >= trial) begin
            srem_q[k][i+1]  <= remsh - trial;
            sroot_q[k][i+1] <= {sroot_q[k][i][29:0], 1'b1};
          end else begin
            srem_q[k][i+1]  <= remsh;
            sroot_q[k][i+1] <= {sroot_q[k][i][29:0], 1'b0};
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax_q[0] <= ggcd_pkg::cw_t'({3'b000, sroot_q[1][QS]});
      ay_q[0] <= ggcd_pkg::cw_t'({3'b000, sroot_q[0][QS]});
      az_q[0] <= '0;
    end
  end

  for (genvar i = 0; i < SS; i++) begin : g_vec
    localparam ggcd_pkg::cw_t AT = ggcd_pkg::cw_t'({2'b00, ggcd_pkg::atan_q30(i)});
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (!ay_q[i][33]) begin
          ax_q[i+1] <= ax_q[i] + (ay_q[i] >>> i);
          ay_q[i+1] <= ay_q[i] - (ax_q[i] >>> i);
          az_q[i+1] <= az_q[i] + AT;
        end else begin
          ax_q[i+1] <= ax_q[i] - (ay_q[i] >>> i);
          ay_q[i+1] <= ay_q[i] + (ax_q[i] >>> i);
          az_q[i+1] <= az_q[i] - AT;
        end
      end
    end
  end

  assign zc       = az_q[SS][33] ? '0 : az_q[SS][32:0];
  assign prod_r   = prod_q + 50'(64'd1 << 25);
  assign dist_raw = prod_r[49:26];

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q <= 50'(radius_q) * 50'({zc, 1'b0});
      dist_q <= (dist_raw > 24'(ggcd_pkg::DIST_SAT)) ?
                ggcd_pkg::DIST_SAT : dist_raw[ggcd_pkg::DIST_W-1:0];
    end
  end

  `GGCD_ASSERT_CLK(a_h_split, !vld_q[ggcd_pkg::H_STAGE] || ((sarg_q[0][0] <= ggcd_pkg::ONE_Q30) && (32'(sarg_q[0][0]) + 32'(sarg_q[1][0]) == 32'(ggcd_pkg::ONE_Q30))), "haversine term out of range")
  `GGCD_ASSERT_CLK(a_sqrt_floor, !vld_q[ggcd_pkg::SQ_END] || ((62'(sroot_q[0][QS]) * 62'(sroot_q[0][QS])) <= {1'b0, sarg_q[0][QS], 30'b0}), "root exceeds its argument")
  `GGCD_ASSERT_NEXT(a_stall_freeze, !en, $stable(vld_q), "pipeline moved while stalled")

endmodule
